@@ design/json_string_unescape_validate_unit_assert.svh @@
// Assertion macros for the JSON string unescape unit.
// Standalone header; no dependencies. Empty bodies under SYNTHESIS.
`ifndef JSON_STRING_UNESCAPE_VALIDATE_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_VALIDATE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset
`define JSU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset
`define JSU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define JSU_ASSERT(lbl, clk, rst_n, prop, msg)
`define JSU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ design/jsu_pkg.sv @@
// Shared types, codes and helpers for the JSON string unescape unit.
// No dependencies; imported by every module of the block.
package jsu_pkg;

  // Limits and fixed values
  localparam int MaxInputBytes = 65536;
  localparam logic [20:0] MaxBytesReset = 21'd1048576;
  localparam logic [15:0] SurHiBase = 16'hD800;
  localparam logic [15:0] SurLoBase = 16'hDC00;
  localparam logic [20:0] SuppBase  = 21'h10000;

  // Parser state
  typedef enum logic [3:0] {
    ModeIdle,
    ModeText,
    ModeEsc,
    ModeHexA,
    ModePairBs,
    ModePairU,
    ModeHexB,
    ModeUtf8
  } mode_e;

  // Result status codes
  typedef enum logic [3:0] {
    StData,
    StDone,
    StQuote,
    StCtrl,
    StUtf8,
    StEscTrunc,
    StEscBad,
    StUniTrunc,
    StUniBad,
    StSurr,
    StLimit,
    StUnterm
  } status_e;

  // Results caused by one input byte: up to four data bytes or one status
  typedef struct packed {
    logic [2:0]       cnt;
    status_e          status;
    logic [3:0][7:0]  data;
  } res_t;

  // Value of an ASCII hex digit; bit 4 set marks a non-digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h10;
    if (b inside {[8'h30:8'h39]}) begin
      v = b - 8'h30;
    end else if (b inside {[8'h61:8'h66]}) begin
      v = b - 8'h61 + 8'd10;
    end else if (b inside {[8'h41:8'h46]}) begin
      v = b - 8'h41 + 8'd10;
    end
    return v[4:0];
  endfunction

  // Continuation bytes that a UTF-8 lead byte needs; 0 for a bad lead
  function automatic logic [1:0] lead_count(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b inside {[8'hC2:8'hDF]}) begin
      n = 2'd1;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      n = 2'd2;
    end else if (b inside {[8'hF0:8'hF4]}) begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

@@ design/jsu_decode.sv @@
// Per-byte parser state and decode logic for the JSON string unescape unit.
// Depends on jsu_pkg. Produces the full result set of one byte combinationally.
module jsu_decode import jsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] bytes_left_i,
  input  logic [20:0] max_bytes_i,
  output res_t        res_o
);

  mode_e       mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] hs_q, hs_d;
  logic [1:0]  dc_q, dc_d;
  logic [7:0]  lead_q, lead_d;
  logic [20:0] cp_q, cp_d;
  logic [1:0]  cl_q, cl_d;
  logic [20:0] cnt_q, cnt_d;

  // Hold parser state; advance only when a byte is stepped through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      acc_q  <= '0;
      hs_q   <= '0;
      dc_q   <= '0;
      lead_q <= '0;
      cp_q   <= '0;
      cl_q   <= '0;
      cnt_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      hs_q   <= hs_d;
      dc_q   <= dc_d;
      lead_q <= lead_d;
      cp_q   <= cp_d;
      cl_q   <= cl_d;
      cnt_q  <= cnt_d;
    end
  end

  // Decode one byte: next state plus the results it causes
  always_comb begin
    logic [15:0] bl;
    logic        err;
    status_e     code;
    logic        have;
    logic [20:0] cp;
    logic [1:0]  n;
    logic [4:0]  d;
    logic [15:0] v;
    logic [20:0] cpn;
    logic [2:0]  len;
    logic [21:0] total_len;

    bl = (32'(bytes_left_i) > MaxInputBytes - 1) ? 16'(MaxInputBytes - 1) : bytes_left_i;
    err    = 1'b0;
    code   = StData;
    have   = 1'b0;
    cp     = '0;
    n      = lead_count(byte_i);
    d      = hex_value(byte_i);
    v      = {acc_q[11:0], d[3:0]};
    cpn    = {cp_q[14:0], byte_i[5:0]};
    mode_d = mode_q;
    acc_d  = acc_q;
    hs_d   = hs_q;
    dc_d   = dc_q;
    lead_d = lead_q;
    cp_d   = cp_q;
    cl_d   = cl_q;
    cnt_d  = cnt_q;

    case (mode_q)
      ModeText: begin
        if (byte_i == 8'h22) begin
          err = 1'b1; code = StDone;
        end else if (byte_i < 8'h20 || byte_i == 8'h7F) begin
          err = 1'b1; code = StCtrl;
        end else if (byte_i[7]) begin
          if (n == 2'd0 || bl < {14'd0, n}) begin
            err = 1'b1; code = StUtf8;
          end else begin
            lead_d = byte_i;
            case (n)
              2'd1:    cp_d = {16'd0, byte_i[4:0]};
              2'd2:    cp_d = {17'd0, byte_i[3:0]};
              default: cp_d = {18'd0, byte_i[2:0]};
            endcase
            cl_d   = n;
            mode_d = ModeUtf8;
          end
        end else if (byte_i == 8'h5C) begin
          if (bl == 16'd0) begin
            err = 1'b1; code = StEscTrunc;
          end else begin
            mode_d = ModeEsc;
          end
        end else begin
          have = 1'b1;
          cp   = {13'd0, byte_i};
        end
      end
      ModeEsc: begin
        mode_d = ModeText;
        if (byte_i inside {8'h22, 8'h5C, 8'h2F}) begin
          have = 1'b1;
          cp   = {13'd0, byte_i};
        end else if (byte_i inside {8'h62, 8'h66, 8'h6E, 8'h72, 8'h74}) begin
          err = 1'b1; code = StCtrl;
        end else if (byte_i == 8'h75) begin
          if (bl < 16'd4) begin
            err = 1'b1; code = StUniTrunc;
          end else begin
            mode_d = ModeHexA;
            dc_d   = '0;
            acc_d  = '0;
          end
        end else begin
          err = 1'b1; code = StEscBad;
        end
      end
      ModeHexA, ModeHexB: begin
        if (d[4]) begin
          err = 1'b1; code = StUniBad;
        end else if (dc_q != 2'd3) begin
          acc_d = v;
          dc_d  = dc_q + 2'd1;
        end else begin
          acc_d = '0;
          dc_d  = '0;
          if (mode_q == ModeHexA) begin
            if (v inside {[SurHiBase:16'hDBFF]}) begin
              if (bl < 16'd6) begin
                err = 1'b1; code = StSurr;
              end else begin
                hs_d   = v;
                mode_d = ModePairBs;
              end
            end else if (v inside {[SurLoBase:16'hDFFF]}) begin
              err = 1'b1; code = StSurr;
            end else begin
              have   = 1'b1;
              cp     = {5'd0, v};
              mode_d = ModeText;
            end
          end else begin
            if (v < SurLoBase || v > 16'hDFFF || hs_q < SurHiBase) begin
              err = 1'b1; code = StSurr;
            end else begin
              // Join the pair: high ten bits from the first unit, low ten from the second
              cp     = SuppBase + {1'b0, hs_q[9:0], v[9:0]};
              have   = 1'b1;
              hs_d   = '0;
              mode_d = ModeText;
            end
          end
        end
      end
      ModePairBs: begin
        if (byte_i == 8'h5C) begin
          mode_d = ModePairU;
        end else begin
          err = 1'b1; code = StSurr;
        end
      end
      ModePairU: begin
        if (byte_i != 8'h75) begin
          err = 1'b1; code = StSurr;
        end else if (bl < 16'd4) begin
          err = 1'b1; code = StUniTrunc;
        end else begin
          mode_d = ModeHexB;
          dc_d   = '0;
          acc_d  = '0;
        end
      end
      ModeUtf8: begin
        if (byte_i < 8'h80 || byte_i > 8'hBF || lead_count(lead_q) == 2'd0 ||
            cl_q == 2'd0) begin
          err = 1'b1; code = StUtf8;
        end else if (cl_q == lead_count(lead_q) &&
                     ((lead_q == 8'hE0 && byte_i < 8'hA0) ||
                      (lead_q == 8'hED && byte_i >= 8'hA0) ||
                      (lead_q == 8'hF0 && byte_i < 8'h90) ||
                      (lead_q == 8'hF4 && byte_i > 8'h8F))) begin
          // Overlong, surrogate or out-of-range form seen at first continuation
          err = 1'b1; code = StUtf8;
        end else begin
          cl_d = cl_q - 2'd1;
          if (cl_q == 2'd1) begin
            have   = 1'b1;
            cp     = cpn;
            cp_d   = '0;
            lead_d = '0;
            mode_d = ModeText;
          end else begin
            cp_d = cpn;
          end
        end
      end
      default: begin
        if (byte_i == 8'h22) begin
          cnt_d  = '0;
          acc_d  = '0;
          hs_d   = '0;
          dc_d   = '0;
          lead_d = '0;
          cp_d   = '0;
          cl_d   = '0;
          mode_d = ModeText;
        end else begin
          err = 1'b1; code = StQuote;
        end
      end
    endcase

    // Encoded length of the decoded character
    if (cp <= 21'h7F) begin
      len = 3'd1;
    end else if (cp <= 21'h7FF) begin
      len = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    total_len = {1'b0, cnt_q} + {19'd0, len};

    // Control check first, then the length limit
    if (!err && have) begin
      if (cp < 21'h20 || (cp >= 21'h7F && cp <= 21'h9F)) begin
        err = 1'b1; code = StCtrl;
      end else if (total_len > {1'b0, max_bytes_i}) begin
        err = 1'b1; code = StLimit;
      end
    end

    res_o.cnt    = '0;
    res_o.status = StData;
    res_o.data   = '0;

    if (err || (mode_d != ModeIdle && bl == 16'd0)) begin
      // Report one status and drop back to idle
      res_o.cnt    = 3'd1;
      res_o.status = err ? code : StUnterm;
      mode_d = ModeIdle;
      acc_d  = '0;
      hs_d   = '0;
      dc_d   = '0;
      lead_d = '0;
      cp_d   = '0;
      cl_d   = '0;
    end else if (have) begin
      res_o.cnt = len;
      case (len)
        3'd1: begin
          res_o.data[0] = cp[7:0];
        end
        3'd2: begin
          res_o.data[0] = {3'b110, cp[10:6]};
          res_o.data[1] = {2'b10, cp[5:0]};
        end
        3'd3: begin
          res_o.data[0] = {4'b1110, cp[15:12]};
          res_o.data[1] = {2'b10, cp[11:6]};
          res_o.data[2] = {2'b10, cp[5:0]};
        end
        default: begin
          res_o.data[0] = {5'b11110, cp[20:18]};
          res_o.data[1] = {2'b10, cp[17:12]};
          res_o.data[2] = {2'b10, cp[11:6]};
          res_o.data[3] = {2'b10, cp[5:0]};
        end
      endcase
      cnt_d = total_len[20:0];
    end
  end

endmodule

@@ design/jsu_burst.sv @@
// Result register and burst drain for the JSON string unescape unit.
// Depends on jsu_pkg. Emits the results of one byte, one per cycle while the output is ready.
module jsu_burst import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_t       res_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [3:0] status_o,
  output logic       last_of_run_o
);

  logic [2:0]      cnt_q, cnt_d;
  logic [1:0]      idx_q, idx_d;
  status_e         status_q;
  logic [3:0][7:0] data_q;
  logic            take;

  assign out_valid_o   = (cnt_q != 3'd0);
  assign last_of_run_o = ({1'b0, idx_q} + 3'd1 == cnt_q);
  assign out_byte_o    = data_q[idx_q];
  assign status_o      = status_q;
  assign take          = out_valid_o && out_ready_i;
  assign free_o        = !out_valid_o || (take && last_of_run_o);

  // Advance through the burst; reload once the last result leaves
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (free_o) begin
      cnt_d = load_i ? res_i.cnt : 3'd0;
      idx_d = '0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Capture payload with each load
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      status_q <= res_i.status;
      data_q   <= res_i.data;
    end
  end

endmodule

@@ design/json_string_unescape_validate_unit.sv @@
// JSON string unescape and UTF-8 validate unit, top level. Uses jsu_pkg, jsu_decode, jsu_burst.
// Path: a request waits in the input register, is decoded combinationally and loads into the result register.
// Throughput: one input byte per cycle while the output is ready and each byte yields at most one result; a byte
// that decodes to n bytes holds the result register until the one-result-per-cycle drain has emitted them all.
// Reset: asynchronous active low; parser idles awaiting a quote, limit register to 1048576.
`include "json_string_unescape_validate_unit_assert.svh"
module json_string_unescape_validate_unit import jsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [20:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic [15:0] bytes_left_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [3:0]  status_o,
  output logic        last_of_run_o
);

  logic [20:0] max_q;
  logic        in_v_q;
  logic [7:0]  byte_q;
  logic [15:0] bl_q;
  logic        res_free;
  logic        move;
  res_t        res;

  assign cfg_ready_o = 1'b1;
  assign move        = in_v_q && res_free;
  assign in_ready_o  = !in_v_q || res_free;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxBytesReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_q <= cfg_data_i;
    end
  end

  // Input register: hold the request until the result register takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      bl_q   <= bytes_left_i;
    end
  end

  jsu_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (move),
    .byte_i       (byte_q),
    .bytes_left_i (bl_q),
    .max_bytes_i  (max_q),
    .res_o        (res)
  );

  jsu_burst u_burst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (move),
    .res_i         (res),
    .free_o        (res_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

  // A status result is always the only, and so the last, result of its byte
  `JSU_ASSERT(a_status_last, clk_i, rst_ni, (out_valid_o && status_o != StData) |-> (last_of_run_o && out_byte_o == 8'd0), "status result not last or carries data")

  // A full input register never takes a new request while the result side stalls
  `JSU_ASSERT_NEVER(a_no_overrun, clk_i, rst_ni, in_v_q && out_valid_o && !out_ready_i && in_ready_o, "input taken while result stalled")

  // An unfinished burst, stalled or not, is never dropped before its last result
  `JSU_ASSERT(a_burst_hold, clk_i, rst_ni, (out_valid_o && !last_of_run_o) |=> out_valid_o, "burst dropped before last result")

endmodule
